[hw/rtl/sre_pkg.sv]
// Shared types and constants of the moving average and RSI signal engine.
`timescale 1ns / 1ps

package sre_pkg;

    localparam int PRICE_W     = 32;
    localparam int RSI_W       = 14;
    localparam int WINDOW_W    = 7;
    localparam int LEVEL_W     = 14;
    localparam int CFG_DATA_W  = 14;
    localparam int CFG_INDEX_W = 2;
    localparam int QUOTIENT_W  = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [RSI_W-1:0]    FULL_SCALE      = 14'd10000;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET    = 7'd14;
    localparam logic [LEVEL_W-1:0]  OVERBOUGHT_RESET = 14'd7000;
    localparam logic [LEVEL_W-1:0]  OVERSOLD_RESET   = 14'd3000;

    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OVERBOUGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_OVERSOLD   = 2'd2;

    typedef enum logic [1:0] {
        SIG_NONE = 2'd0,
        SIG_BUY  = 2'd1,
        SIG_SELL = 2'd2
    } signal_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_RD1,
        F_RD2,
        F_UPD
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_PREP,
        B_START,
        B_DIV
    } back_state_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] overbought;
        logic [LEVEL_W-1:0] oversold;
    } levels_t;

endpackage

[hw/rtl/sre_if.sv]
// Request and result channel interfaces of the signal engine.
`timescale 1ns / 1ps

interface sre_price_if;
    logic                           valid;
    logic                           ready;
    logic [sre_pkg::PRICE_W-1:0]    close_price;
    logic                           new_series;

    modport source (output valid, output close_price, output new_series, input ready);
    modport sink   (input valid, input close_price, input new_series, output ready);
endinterface

interface sre_result_if;
    logic                           valid;
    logic                           ready;
    logic [sre_pkg::PRICE_W-1:0]    moving_average;
    logic                           average_valid;
    logic [sre_pkg::RSI_W-1:0]      strength_index;
    logic                           index_valid;
    logic [1:0]                     momentum_signal;
    logic [1:0]                     trend_signal;

    modport source (output valid, output moving_average, output average_valid,
                    output strength_index, output index_valid,
                    output momentum_signal, output trend_signal, input ready);
    modport sink   (input valid, input moving_average, input average_valid,
                    input strength_index, input index_valid,
                    input momentum_signal, input trend_signal, output ready);
endinterface

[hw/rtl/sma_rsi_signal_engine.sv]
// Top level of the moving average and RSI signal engine.
`timescale 1ns / 1ps

// Usage
//   price_chan carries one request per closing price: close_price and the
//   new_series flag, which clears the ring and running totals first.
//   result_chan returns exactly one result per request, in order: the simple
//   moving average, the RSI in hundredths of a percent, their valid flags and
//   the buy/sell signals. wr_en/wr_index/wr_data write the window length
//   (which also clears the series) and the two RSI thresholds; write them
//   only while no request is in flight.
// Sequencing
//   A request passes the front states (ring reads, total update), then the
//   back part, where the two 32-step restoring dividers run side by side;
//   the back part takes no new request before it has loaded its result.
// Reset
//   rst_n clears the series state, empties the queue and output register and
//   restores the register defaults (window 14, levels 7000 and 3000).
// Stalls
//   A result waits in the output register while result_chan is stalled; the
//   back part finishes the next request meanwhile, and the front part keeps
//   taking requests until the two-entry queue between them fills.
module sma_rsi_signal_engine #(
    parameter int MAX_WINDOW = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    sre_price_if.sink                           price_chan,
    sre_result_if.source                        result_chan,
    input  logic                                wr_en,
    input  logic [sre_pkg::CFG_INDEX_W-1:0]     wr_index,
    input  logic [sre_pkg::CFG_DATA_W-1:0]      wr_data
);
    import sre_pkg::*;

    localparam int CW      = $clog2(MAX_WINDOW + 2);
    localparam int TW      = PRICE_W + $clog2(MAX_WINDOW + 1);
    localparam int ENTRY_W = PRICE_W + 3*TW + CW + 2;

    logic [WINDOW_W-1:0]    window_reg, window_next;
    logic [LEVEL_W-1:0]     overbought_reg, overbought_next;
    logic [LEVEL_W-1:0]     oversold_reg, oversold_next;
    logic                   series_clear;
    levels_t                levels;

    logic                   push;
    logic [ENTRY_W-1:0]     entry;
    logic                   queue_full;
    logic                   pop;
    logic                   head_valid;
    logic [ENTRY_W-1:0]     head_data;

    // Register writes; an index beyond the list is dropped.
    always_comb
    begin
        window_next     = window_reg;
        overbought_next = overbought_reg;
        oversold_next   = oversold_reg;
        series_clear    = 1'b0;
        if (wr_en)
        begin
            case (wr_index)
                REG_WINDOW:
                begin
                    window_next  = wr_data[WINDOW_W-1:0];
                    series_clear = 1'b1;
                end
                REG_OVERBOUGHT:
                begin
                    overbought_next = wr_data;
                end
                REG_OVERSOLD:
                begin
                    oversold_next = wr_data;
                end
                default:
                begin
                    series_clear = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg     <= WINDOW_RESET;
            overbought_reg <= OVERBOUGHT_RESET;
            oversold_reg   <= OVERSOLD_RESET;
        end
        else
        begin
            window_reg     <= window_next;
            overbought_reg <= overbought_next;
            oversold_reg   <= oversold_next;
        end
    end

    assign levels.overbought = overbought_reg;
    assign levels.oversold   = oversold_reg;

    sre_front #(
        .MAX_WINDOW (MAX_WINDOW),
        .ENTRY_W    (ENTRY_W)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (price_chan),
        .window_length (window_reg),
        .series_clear  (series_clear),
        .queue_full    (queue_full),
        .push          (push),
        .entry         (entry)
    );

    sre_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (entry),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    sre_back #(
        .MAX_WINDOW (MAX_WINDOW),
        .ENTRY_W    (ENTRY_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .levels     (levels),
        .res        (result_chan)
    );

endmodule

[hw/rtl/sre_div.sv]
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module sre_div #(
    parameter int DVD_W = 40,
    parameter int DVS_W = 39
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [DVD_W-1:0]                    dividend,
    input  logic [DVS_W-1:0]                    divisor,
    output logic                                busy,
    output logic [sre_pkg::QUOTIENT_W-1:0]      quotient
);
    import sre_pkg::*;

    localparam int CNT_W = $clog2(QUOTIENT_W + 1);

    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [DVS_W-1:0]       rem_reg, rem_next;
    logic [DVS_W-1:0]       dvs_reg, dvs_next;
    logic [QUOTIENT_W-1:0]  quo_reg, quo_next;
    logic [DVS_W:0]         trial;
    logic [DVS_W:0]         diff;

    // Dividend bits above the quotient range start in the remainder; the
    // caller guarantees the quotient fits, so they stay below the divisor.
    always_comb
    begin
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        quo_next = quo_reg;
        trial    = {rem_reg, quo_reg[QUOTIENT_W-1]};
        diff     = trial - {1'b0, dvs_reg};
        if (start)
        begin
            cnt_next = CNT_W'(QUOTIENT_W);
            rem_next = DVS_W'(dividend >> QUOTIENT_W);
            dvs_next = divisor;
            quo_next = dividend[QUOTIENT_W-1:0];
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = DVS_W'(diff);
                quo_next = {quo_reg[QUOTIENT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = DVS_W'(trial);
                quo_next = {quo_reg[QUOTIENT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = quo_reg;

endmodule

[hw/rtl/sre_queue.sv]
// Short first-in first-out queue between the front and back parts.
`timescale 1ns / 1ps

module sre_queue #(
    parameter int WIDTH = 160,
    parameter int DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [WIDTH-1:0]    push_data,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output logic [WIDTH-1:0]    head_data
);
    import sre_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]   slots [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = slots[rd_ptr_reg];

endmodule

[hw/rtl/sre_front.sv]
// Front part: takes a price, reads the ring and updates the running totals.
`timescale 1ns / 1ps

module sre_front #(
    parameter int MAX_WINDOW = 64,
    parameter int ENTRY_W    = 160
) (
    input  logic                            clk,
    input  logic                            rst_n,
    sre_price_if.sink                       req,
    input  logic [sre_pkg::WINDOW_W-1:0]    window_length,
    input  logic                            series_clear,
    input  logic                            queue_full,
    output logic                            push,
    output logic [ENTRY_W-1:0]              entry
);
    import sre_pkg::*;

    localparam int DEPTH = MAX_WINDOW + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_WINDOW + 2);
    localparam int TW    = PRICE_W + $clog2(MAX_WINDOW + 1);

    front_state_t       state_reg, state_next;
    logic [AW-1:0]      wpos_reg, wpos_next;
    logic [CW-1:0]      seen_reg, seen_next;
    logic [TW-1:0]      ptotal_reg, ptotal_next;
    logic [TW-1:0]      gain_reg, gain_next;
    logic [TW-1:0]      loss_reg, loss_next;
    logic [PRICE_W-1:0] price_reg, price_next;

    logic [PRICE_W-1:0] ring [DEPTH];
    logic [PRICE_W-1:0] rd_a_reg;
    logic [PRICE_W-1:0] rd_b_reg;
    logic [AW-1:0]      addr_a;

    logic [CW-1:0]      n_eff;
    logic [CW-1:0]      n_plus1;
    logic [CW:0]        seen_plus1;
    logic [AW-1:0]      back_1;
    logic [AW-1:0]      back_n;
    logic [AW-1:0]      back_n1;
    logic [PRICE_W-1:0] diff_up;
    logic [PRICE_W-1:0] diff_dn;
    logic [PRICE_W-1:0] diff_old_up;
    logic [PRICE_W-1:0] diff_old_dn;
    logic [TW-1:0]      drop_price;
    logic               avg_ok;
    logic               rsi_ok;

    // Ring position k entries behind the write position, k in 1..DEPTH.
    function automatic logic [AW-1:0] ring_back(input logic [AW-1:0] pos,
                                                input logic [CW-1:0] k);
        logic [AW:0] t;
        t = (AW+1)'(pos) + (AW+1)'(DEPTH) - (AW+1)'(k);
        if (t >= (AW+1)'(DEPTH))
        begin
            t = t - (AW+1)'(DEPTH);
        end
        return AW'(t);
    endfunction

    always_comb
    begin
        if (window_length == '0)
        begin
            n_eff = CW'(1);
        end
        else if (32'(window_length) > 32'(MAX_WINDOW))
        begin
            n_eff = CW'(MAX_WINDOW);
        end
        else
        begin
            n_eff = CW'(window_length);
        end
    end

    assign n_plus1     = n_eff + 1'b1;
    assign seen_plus1  = {1'b0, seen_reg} + 1'b1;
    assign back_1      = ring_back(wpos_reg, CW'(1));
    assign back_n      = ring_back(wpos_reg, n_eff);
    assign back_n1     = ring_back(wpos_reg, n_plus1);
    assign addr_a      = (state_reg == F_RD1) ? back_1 : back_n1;
    assign diff_up     = price_reg - rd_a_reg;
    assign diff_dn     = rd_a_reg - price_reg;
    assign diff_old_up = rd_b_reg - rd_a_reg;
    assign diff_old_dn = rd_a_reg - rd_b_reg;
    assign drop_price  = (seen_reg >= n_eff) ? TW'(rd_b_reg) : '0;
    assign avg_ok      = (seen_plus1 >= {1'b0, n_eff});
    assign rsi_ok      = (seen_reg >= n_eff);

    always_comb
    begin
        state_next  = state_reg;
        wpos_next   = wpos_reg;
        seen_next   = seen_reg;
        ptotal_next = ptotal_reg;
        gain_next   = gain_reg;
        loss_next   = loss_reg;
        price_next  = price_reg;
        push        = 1'b0;
        req.ready   = (state_reg == F_IDLE) && !queue_full;
        case (state_reg)
            F_IDLE:
            begin
                if (req.valid && !queue_full)
                begin
                    price_next = req.close_price;
                    if (req.new_series)
                    begin
                        wpos_next   = '0;
                        seen_next   = '0;
                        ptotal_next = '0;
                        gain_next   = '0;
                        loss_next   = '0;
                    end
                    state_next = F_RD1;
                end
            end
            F_RD1:
            begin
                state_next = F_RD2;
            end
            F_RD2:
            begin
                // Add the newest change; rd_a holds the previous price.
                if (seen_reg != '0)
                begin
                    if (price_reg > rd_a_reg)
                    begin
                        gain_next = gain_reg + TW'(diff_up);
                    end
                    else
                    begin
                        loss_next = loss_reg + TW'(diff_dn);
                    end
                end
                ptotal_next = ptotal_reg + TW'(price_reg) - drop_price;
                state_next  = F_UPD;
            end
            F_UPD:
            begin
                // Drop the change that leaves the window; rd_b newer, rd_a older.
                if (seen_reg >= n_plus1)
                begin
                    if (rd_b_reg > rd_a_reg)
                    begin
                        gain_next = gain_reg - TW'(diff_old_up);
                    end
                    else
                    begin
                        loss_next = loss_reg - TW'(diff_old_dn);
                    end
                end
                wpos_next  = (wpos_reg == AW'(DEPTH - 1)) ? '0 : wpos_reg + 1'b1;
                seen_next  = (seen_reg < n_plus1) ? CW'(seen_plus1) : n_plus1;
                push       = 1'b1;
                state_next = F_IDLE;
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
        if (series_clear)
        begin
            wpos_next   = '0;
            seen_next   = '0;
            ptotal_next = '0;
            gain_next   = '0;
            loss_next   = '0;
        end
    end

    assign entry = {price_reg, ptotal_reg, gain_next, loss_next, n_eff, avg_ok, rsi_ok};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_IDLE;
            wpos_reg   <= '0;
            seen_reg   <= '0;
            ptotal_reg <= '0;
            gain_reg   <= '0;
            loss_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            wpos_reg   <= wpos_next;
            seen_reg   <= seen_next;
            ptotal_reg <= ptotal_next;
            gain_reg   <= gain_next;
            loss_reg   <= loss_next;
        end
    end

    always_ff @(posedge clk)
    begin
        price_reg <= price_next;
        rd_a_reg  <= ring[addr_a];
        rd_b_reg  <= ring[back_n];
        if (state_reg == F_UPD)
        begin
            ring[wpos_reg] <= price_reg;
        end
    end

endmodule

[hw/rtl/sre_back.sv]
// Back part: divides the totals and forms the indicator signals.
`timescale 1ns / 1ps

module sre_back #(
    parameter int MAX_WINDOW = 64,
    parameter int ENTRY_W    = 160
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  logic [ENTRY_W-1:0]  head_data,
    output logic                pop,
    input  sre_pkg::levels_t    levels,
    sre_result_if.source        res
);
    import sre_pkg::*;

    localparam int CW = $clog2(MAX_WINDOW + 2);
    localparam int TW = PRICE_W + $clog2(MAX_WINDOW + 1);
    localparam int NW = TW + RSI_W;

    back_state_t        state_reg, state_next;
    logic [PRICE_W-1:0] price_reg;
    logic [TW-1:0]      ptotal_reg;
    logic [TW-1:0]      gain_reg;
    logic [TW-1:0]      loss_reg;
    logic [CW-1:0]      n_reg;
    logic               avg_ok_reg;
    logic               rsi_ok_reg;
    logic [NW-1:0]      num_reg;

    logic               out_valid_reg, out_valid_next;
    logic [PRICE_W-1:0] avg_out_reg;
    logic               avg_ok_out_reg;
    logic [RSI_W-1:0]   rsi_out_reg;
    logic               rsi_ok_out_reg;
    signal_t            mom_out_reg;
    signal_t            trend_out_reg;

    logic               start;
    logic               load;
    logic               avg_busy;
    logic               rsi_busy;
    logic [QUOTIENT_W-1:0] avg_quo;
    logic [QUOTIENT_W-1:0] rsi_quo;
    logic [TW-1:0]      rsi_den;
    logic [PRICE_W-1:0] avg_val;
    logic [RSI_W-1:0]   rsi_val;
    signal_t            mom_val;
    signal_t            trend_val;

    assign rsi_den = gain_reg + loss_reg;

    sre_div #(
        .DVD_W (TW),
        .DVS_W (CW)
    ) u_avg_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .dividend (ptotal_reg),
        .divisor  (n_reg),
        .busy     (avg_busy),
        .quotient (avg_quo)
    );

    sre_div #(
        .DVD_W (NW),
        .DVS_W (TW)
    ) u_rsi_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .dividend (num_reg),
        .divisor  (rsi_den),
        .busy     (rsi_busy),
        .quotient (rsi_quo)
    );

    always_comb
    begin
        avg_val   = avg_ok_reg ? avg_quo : '0;
        trend_val = SIG_NONE;
        if (avg_ok_reg)
        begin
            if (price_reg > avg_quo)
            begin
                trend_val = SIG_BUY;
            end
            else if (price_reg < avg_quo)
            begin
                trend_val = SIG_SELL;
            end
        end
        rsi_val = '0;
        mom_val = SIG_NONE;
        if (rsi_ok_reg)
        begin
            rsi_val = (loss_reg == '0) ? FULL_SCALE : rsi_quo[RSI_W-1:0];
            if (rsi_val > levels.overbought)
            begin
                mom_val = SIG_SELL;
            end
            else if (rsi_val < levels.oversold)
            begin
                mom_val = SIG_BUY;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        pop            = 1'b0;
        start          = 1'b0;
        load           = 1'b0;
        out_valid_next = out_valid_reg && !res.ready;
        case (state_reg)
            B_IDLE:
            begin
                if (head_valid)
                begin
                    pop        = 1'b1;
                    state_next = B_PREP;
                end
            end
            B_PREP:
            begin
                state_next = B_START;
            end
            B_START:
            begin
                start      = 1'b1;
                state_next = B_DIV;
            end
            B_DIV:
            begin
                // Hold the finished result until the output register is free.
                if (!avg_busy && !rsi_busy && (!out_valid_reg || res.ready))
                begin
                    load           = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rsi_ok_reg <= head_data[0];
            avg_ok_reg <= head_data[1];
            n_reg      <= head_data[2 +: CW];
            loss_reg   <= head_data[2 + CW +: TW];
            gain_reg   <= head_data[2 + CW + TW +: TW];
            ptotal_reg <= head_data[2 + CW + 2*TW +: TW];
            price_reg  <= head_data[2 + CW + 3*TW +: PRICE_W];
        end
        if (state_reg == B_PREP)
        begin
            num_reg <= NW'(gain_reg) * NW'(FULL_SCALE);
        end
        if (load)
        begin
            avg_out_reg    <= avg_val;
            avg_ok_out_reg <= avg_ok_reg;
            rsi_out_reg    <= rsi_val;
            rsi_ok_out_reg <= rsi_ok_reg;
            mom_out_reg    <= mom_val;
            trend_out_reg  <= trend_val;
        end
    end

    assign res.valid           = out_valid_reg;
    assign res.moving_average  = avg_out_reg;
    assign res.average_valid   = avg_ok_out_reg;
    assign res.strength_index  = rsi_out_reg;
    assign res.index_valid     = rsi_ok_out_reg;
    assign res.momentum_signal = mom_out_reg;
    assign res.trend_signal    = trend_out_reg;

endmodule

[test/sre_engine_checker.sv]
`timescale 1ns / 1ps
// Result predictor and comparator for the signal engine, fed from the observed channels.

module sre_engine_checker #(
    parameter int MAX_WINDOW = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    sre_price_if                            price_chan,
    sre_result_if                           result_chan,
    input  logic                            wr_en,
    input  logic [sre_pkg::CFG_INDEX_W-1:0] wr_index,
    input  logic [sre_pkg::CFG_DATA_W-1:0]  wr_data,
    output int                              fail_count,
    output int                              pending
);
    import sre_pkg::*;

    localparam int RING_DEPTH = MAX_WINDOW + 1;

    typedef struct packed {
        logic [PRICE_W-1:0] average;
        logic               avg_ok;
        logic [RSI_W-1:0]   strength;
        logic               rsi_ok;
        signal_t            momentum;
        signal_t            trend;
    } engine_result_t;

    logic [PRICE_W-1:0]  price_hist [RING_DEPTH];
    int unsigned         hist_pos;
    logic [37:0]         price_sum;
    logic [37:0]         gain_sum;
    logic [37:0]         loss_sum;
    logic [WINDOW_W-1:0] seen;
    logic [WINDOW_W-1:0] window_reg;
    logic [LEVEL_W-1:0]  overbought;
    logic [LEVEL_W-1:0]  oversold;

    engine_result_t      expected_q [$];
    engine_result_t      want;
    engine_result_t      got;
    int                  errors;
    int                  result_no;

    function automatic logic [PRICE_W-1:0] recall(int unsigned back);
        return price_hist[(hist_pos + RING_DEPTH - back) % RING_DEPTH];
    endfunction

    function automatic string describe(engine_result_t r);
        return $sformatf("avg %0d/%0b rsi %0d/%0b mom %0d trend %0d",
                         r.average, r.avg_ok, r.strength, r.rsi_ok, r.momentum, r.trend);
    endfunction

    task automatic clear_series();
        hist_pos  = 0;
        price_sum = '0;
        gain_sum  = '0;
        loss_sum  = '0;
        seen      = '0;
    endtask

    // Update the running totals with one price and work out the result it gives.
    task automatic forecast(input logic [PRICE_W-1:0] price, input logic fresh,
                            output engine_result_t r);
        int unsigned        n;
        logic [PRICE_W-1:0] prev;
        logic [PRICE_W-1:0] newer;
        logic [PRICE_W-1:0] older;
        logic [63:0]        gain_wide;
        logic [63:0]        quotient;

        n = (window_reg == 0) ? 1 : (window_reg > MAX_WINDOW) ? MAX_WINDOW : window_reg;
        if (fresh)
            clear_series();

        // all ring reads come before the new price is stored
        if (seen >= 1) begin
            prev = recall(1);
            if (price > prev)
                gain_sum += 38'(price - prev);
            else
                loss_sum += 38'(prev - price);
        end
        if (seen >= n + 1) begin
            newer = recall(n);
            older = recall(n + 1);
            if (newer > older)
                gain_sum -= 38'(newer - older);
            else
                loss_sum -= 38'(older - newer);
        end
        price_sum += 38'(price);
        if (seen >= n)
            price_sum -= 38'(recall(n));

        price_hist[hist_pos] = price;
        hist_pos = (hist_pos + 1) % RING_DEPTH;
        if (seen < n + 1)
            seen++;

        r          = '0;
        r.avg_ok   = (seen >= n);
        r.rsi_ok   = (seen >= n + 1);
        r.momentum = SIG_NONE;
        r.trend    = SIG_NONE;

        if (r.avg_ok) begin
            quotient  = 64'(price_sum) / 64'(n);
            r.average = quotient[PRICE_W-1:0];
            if (price > r.average)
                r.trend = SIG_BUY;
            else if (price < r.average)
                r.trend = SIG_SELL;
        end
        if (r.rsi_ok) begin
            if (loss_sum == 0) begin
                r.strength = FULL_SCALE;
            end
            else begin
                gain_wide  = 64'(gain_sum);
                quotient   = (gain_wide * 64'(FULL_SCALE)) / (gain_wide + 64'(loss_sum));
                r.strength = quotient[RSI_W-1:0];
            end
            if (r.strength > overbought)
                r.momentum = SIG_SELL;
            else if (r.strength < oversold)
                r.momentum = SIG_BUY;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            window_reg = WINDOW_RESET;
            overbought = OVERBOUGHT_RESET;
            oversold   = OVERSOLD_RESET;
            clear_series();
            expected_q.delete();
            errors     = 0;
            result_no  = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else begin
            // compare results first: a request taken at this edge cannot be answered yet
            if (result_chan.valid && result_chan.ready) begin
                got.average  = result_chan.moving_average;
                got.avg_ok   = result_chan.average_valid;
                got.strength = result_chan.strength_index;
                got.rsi_ok   = result_chan.index_valid;
                got.momentum = signal_t'(result_chan.momentum_signal);
                got.trend    = signal_t'(result_chan.trend_signal);
                if (expected_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("result %0d arrived with nothing expected: %s",
                                 result_no, describe(got));
                end
                else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        errors++;
                        if (errors <= 10)
                            $display("result %0d mismatch: expected %s, got %s",
                                     result_no, describe(want), describe(got));
                    end
                end
                result_no++;
            end

            if (wr_en) begin
                case (wr_index)
                    REG_WINDOW: begin
                        window_reg = wr_data[WINDOW_W-1:0];
                        clear_series();
                    end
                    REG_OVERBOUGHT: overbought = wr_data[LEVEL_W-1:0];
                    REG_OVERSOLD:   oversold   = wr_data[LEVEL_W-1:0];
                    default: ;
                endcase
            end

            if (price_chan.valid && price_chan.ready) begin
                forecast(price_chan.close_price, price_chan.new_series, want);
                expected_q = {expected_q, want};
            end

            fail_count <= errors;
            pending    <= expected_q.size();
        end
    end

endmodule

[test/sma_rsi_signal_engine_tb.sv]
`timescale 1ns / 1ps
// Stimulus and verdict for the moving average and RSI signal engine.

module sma_rsi_signal_engine_tb;
    import sre_pkg::*;

    localparam int     MAX_WINDOW      = 64;
    localparam int     RANDOM_REQUESTS = 2000;
    localparam int     DRAIN_CYCLES    = 60;
    localparam longint CYCLE_LIMIT     = 3_000_000;

    // an index past the register list: the block must ignore writes to it
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    // shapes of the price series fed during a random phase
    typedef enum logic [2:0] {
        TRACE_WALK,
        TRACE_NOISE,
        TRACE_RISE,
        TRACE_FALL,
        TRACE_FLAT
    } trace_t;

    logic                   clk;
    logic                   rst_n;
    logic                   wr_en;
    logic [CFG_INDEX_W-1:0] wr_index;
    logic [CFG_DATA_W-1:0]  wr_data;

    int     fail_count;
    int     pending;
    longint cycle_count = 0;

    // stimulus shaping; steady is shared by the sender and the receiver
    bit     steady;
    int     random_sent;
    int     win_eff;
    trace_t trace;
    longint level;
    longint span;

    sre_price_if  price_chan ();
    sre_result_if result_chan ();

    sma_rsi_signal_engine #(
        .MAX_WINDOW (MAX_WINDOW)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .price_chan  (price_chan),
        .result_chan (result_chan),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data)
    );

    sre_engine_checker #(
        .MAX_WINDOW (MAX_WINDOW)
    ) result_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .price_chan  (price_chan),
        .result_chan (result_chan),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Abandon the run if the block stops answering.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Draw an idle gap: mostly none or short, now and then a long one.
    // Steady phases run with no gaps at all.
    function automatic int draw_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 15);
        if (r < 9)
            return 0;
        if (r < 14)
            return $urandom_range(1, 3);
        return $urandom_range(12, 70);
    endfunction

    // Produce the next price of the current series shape, held inside 32 bits.
    function automatic logic [PRICE_W-1:0] next_price();
        case (trace)
            TRACE_NOISE: level = $urandom;
            TRACE_RISE:  level += $urandom_range(0, span);
            TRACE_FALL:  level -= $urandom_range(0, span);
            TRACE_WALK:  level += longint'($urandom_range(0, 2 * span)) - span;
            default: ;
        endcase
        if (level < 0)
            level = 0;
        if (level > 64'hFFFF_FFFF)
            level = 64'hFFFF_FFFF;
        return level[PRICE_W-1:0];
    endfunction

    // Pick a threshold: both extremes now and then, otherwise anywhere in range.
    function automatic logic [CFG_DATA_W-1:0] pick_level();
        int r;
        r = $urandom_range(0, 5);
        if (r == 0)
            return '0;
        if (r == 1)
            return 14'd10000;
        return CFG_DATA_W'($urandom_range(0, 10000));
    endfunction

    // Offer one request after a random gap and hold it until the block takes it.
    // Returns at the edge of acceptance, with valid still high, so that a
    // back-to-back request keeps valid up without a drop.
    task automatic send_price(input logic [PRICE_W-1:0] price, input logic fresh);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            price_chan.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        price_chan.valid       <= 1'b1;
        price_chan.close_price <= price;
        price_chan.new_series  <= fresh;
        do
            @(posedge clk);
        while (!price_chan.ready);
    endtask

    // Drop valid and wait until every outstanding request has been answered.
    // The first edge lets the checker count the request just taken.
    task automatic settle();
        price_chan.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Pulse one register write; the block must be idle.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        wr_en    <= 1'b0;
        @(posedge clk);
    endtask

    // Write the window length, optionally with junk above its seven bits,
    // and track the length the block will actually use.
    task automatic set_window(input int w, input bit junk_high);
        logic [CFG_DATA_W-1:0] data;
        data = '0;
        data[WINDOW_W-1:0] = w[WINDOW_W-1:0];
        if (junk_high)
            data[CFG_DATA_W-1:WINDOW_W] = (CFG_DATA_W - WINDOW_W)'($urandom);
        write_reg(REG_WINDOW, data);
        if (w[WINDOW_W-1:0] == 0)
            win_eff = 1;
        else if (w[WINDOW_W-1:0] > MAX_WINDOW)
            win_eff = MAX_WINDOW;
        else
            win_eff = int'(w[WINDOW_W-1:0]);
    endtask

    // Result side: hold ready high for a while, then stall it for a random gap.
    initial
    begin
        int hold;
        int gap;
        forever
        begin
            result_chan.ready <= 1'b1;
            hold = $urandom_range(1, 30);
            repeat (hold) @(posedge clk);
            gap = draw_gap();
            if (gap > 0)
            begin
                result_chan.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    initial
    begin
        int i;
        int pick;
        int n_items;

        // drive every input to a known value before the first edge
        price_chan.valid       <= 1'b0;
        price_chan.close_price <= '0;
        price_chan.new_series  <= 1'b0;
        wr_en                  <= 1'b0;
        wr_index               <= REG_WINDOW;
        wr_data                <= '0;
        rst_n                  <= 1'b0;
        steady      = 1'b0;
        random_sent = 0;
        win_eff     = WINDOW_RESET;
        trace       = TRACE_FLAT;
        level       = 0;
        span        = 1;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, default window of 14: swing between the price extremes
        // so both averages fill with the largest gains and losses, then restart
        // the series mid-stream with a mid-scale price.
        for (i = 0; i < 16; i++)
            send_price(i[0] ? 32'hFFFF_FFFF : 32'h0, i == 0);
        send_price(32'h8000_0000, 1'b1);

        // Window of one: a flat change gives full scale with zero loss, then a
        // falling change, then a restart.
        settle();
        set_window(1, 1'b0);
        send_price(32'd500, 1'b0);
        send_price(32'd500, 1'b0);
        send_price(32'd400, 1'b0);
        send_price(32'd400, 1'b1);

        // Window of zero with junk in the upper data bits: used as one.
        settle();
        set_window(0, 1'b1);
        send_price(32'hFFFF_FFFF, 1'b0);
        send_price(32'h0, 1'b0);

        // Threshold extremes: every valid RSI is above the overbought level of
        // zero or below the oversold level of full scale. A write past the
        // register list must change nothing.
        settle();
        write_reg(REG_OVERBOUGHT, '0);
        write_reg(REG_OVERSOLD, 14'd10000);
        write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        send_price(32'd5, 1'b0);
        send_price(32'd7, 1'b0);
        send_price(32'd3, 1'b0);

        // Random part: phases of well-formed series under changing settings.
        while (random_sent < RANDOM_REQUESTS)
        begin
            settle();

            if ($urandom_range(0, 1) == 0)
            begin
                pick = $urandom_range(0, 19);
                case (pick)
                    0:       set_window(0, $urandom_range(0, 3) == 0);
                    1:       set_window(1, $urandom_range(0, 3) == 0);
                    2:       set_window(MAX_WINDOW, $urandom_range(0, 3) == 0);
                    3:       set_window($urandom_range(MAX_WINDOW + 1, 127),
                                        $urandom_range(0, 3) == 0);
                    default: set_window($urandom_range(2, 12), $urandom_range(0, 3) == 0);
                endcase
            end
            if ($urandom_range(0, 2) == 0)
                write_reg(REG_OVERBOUGHT, pick_level());
            if ($urandom_range(0, 2) == 0)
                write_reg(REG_OVERSOLD, pick_level());
            if ($urandom_range(0, 15) == 0)
                write_reg(REG_UNUSED, CFG_DATA_W'($urandom));

            steady = ($urandom_range(0, 3) == 0);
            trace  = trace_t'($urandom_range(0, 4));
            case ($urandom_range(0, 3))
                0:       span = 1;
                1:       span = 100;
                2:       span = 10000;
                default: span = 1 << 20;
            endcase
            case ($urandom_range(0, 5))
                0:       level = 0;
                1:       level = 64'hFFFF_FFFF;
                default: level = $urandom;
            endcase

            // long enough to fill both averages and slide past them
            n_items = 2 * win_eff + $urandom_range(10, 60);
            repeat (n_items)
            begin
                // now and then hold off until the block has answered everything
                if ($urandom_range(0, 299) == 0)
                    settle();
                send_price(next_price(), $urandom_range(0, 49) == 0);
                random_sent++;
            end
        end

        // Drain: wait for the last results, then a little longer for strays.
        price_chan.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
